### src/work_stealing_deque_assert.svh
// Assertion macros for the work-stealing deque.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the including scope.
`ifndef WORK_STEALING_DEQUE_ASSERT_SVH
`define WORK_STEALING_DEQUE_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define WSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define WSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/wsd_pkg.sv
// Shared types and constants of the work-stealing deque.
// No dependencies; imported by the front end, the back end and the top level.
package wsd_pkg;

  localparam int unsigned JOB_W = 32;
  localparam int unsigned OCC_W = 7;
  localparam int unsigned CNT_W = 32;

  // Entries of the command queue between front and back, and of the result queue.
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned RSPQ_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_STEAL = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_NULL  = 2'd3
  } status_e;

  typedef struct packed {
    mode_e            mode;
    logic [JOB_W-1:0] job_handle;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [JOB_W-1:0] job_out;
    logic [OCC_W-1:0] occupancy;
    logic [CNT_W-1:0] push_total;
    logic [CNT_W-1:0] pop_total;
    logic [CNT_W-1:0] steal_total;
    logic [CNT_W-1:0] steal_try_total;
  } rsp_t;

  // What the front end hands to the back end: one ring access and a prepared result.
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [JOB_W-1:0] wdata;
    rsp_t             rsp;
  } cmd_t;

endpackage

### src/wsd_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module wsd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/wsd_fifo.sv
// Small first-in first-out queue built from registers, with a fill level.
// No dependencies; used for the command queue and the result queue.
module wsd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [LW-1:0]    level_q, level_d;
  logic             do_push, do_pop;

  assign full_o  = (level_q == LW'(DEPTH));
  assign empty_o = (level_q == '0);
  assign level_o = level_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (do_pop && !do_push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/wsd_front.sv
// Front end of the deque: accepts requests, classifies them against the pointers,
// and updates pointers and counters. Depends on wsd_pkg.
module wsd_front import wsd_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_push_i,
  output logic                     req_full_o,
  input  req_t                     req_i,
  input  logic                     cmdq_full_i,
  output logic                     cmd_push_o,
  output cmd_t                     cmd_o,
  output logic [$clog2(DEPTH)-1:0] cmd_addr_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned HW = (CW > OCC_W) ? CW : OCC_W;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  // Each pointer is a slot index plus a lap bit, which counts modulo twice the depth.
  logic             top_lap_q, top_lap_d;
  logic [IW-1:0]    top_idx_q, top_idx_d;
  logic             bot_lap_q, bot_lap_d;
  logic [IW-1:0]    bot_idx_q, bot_idx_d;
  logic [CNT_W-1:0] push_cnt_q, push_cnt_d;
  logic [CNT_W-1:0] pop_cnt_q, pop_cnt_d;
  logic [CNT_W-1:0] steal_cnt_q, steal_cnt_d;
  logic [CNT_W-1:0] try_cnt_q, try_cnt_d;
  logic [HW-1:0]    held_now, held_next;
  logic             accept;
  status_e          status;
  logic             wr, rd;
  logic [IW-1:0]    addr;

  function automatic logic [HW-1:0] held_f(input logic tl, input logic [IW-1:0] ti,
                                           input logic bl, input logic [IW-1:0] bi);
    logic [HW-1:0] base;
    base = (tl == bl) ? '0 : HW'(DEPTH);
    return base + HW'(bi) - HW'(ti);
  endfunction

  assign accept     = req_push_i && !cmdq_full_i;
  assign req_full_o = cmdq_full_i;
  assign cmd_push_o = accept;
  assign held_now   = held_f(top_lap_q, top_idx_q, bot_lap_q, bot_idx_q);
  assign held_next  = held_f(top_lap_d, top_idx_d, bot_lap_d, bot_idx_d);

  always_comb begin
    top_lap_d   = top_lap_q;
    top_idx_d   = top_idx_q;
    bot_lap_d   = bot_lap_q;
    bot_idx_d   = bot_idx_q;
    push_cnt_d  = push_cnt_q;
    pop_cnt_d   = pop_cnt_q;
    steal_cnt_d = steal_cnt_q;
    try_cnt_d   = try_cnt_q;
    status      = STATUS_DONE;
    wr          = 1'b0;
    rd          = 1'b0;
    addr        = bot_idx_q;
    unique case (req_i.mode)
      MODE_PUSH: begin
        if (req_i.job_handle == '0) begin
          status = STATUS_NULL;
        end else if (held_now == HW'(DEPTH)) begin
          status = STATUS_FULL;
        end else begin
          wr         = 1'b1;
          addr       = bot_idx_q;
          bot_idx_d  = (bot_idx_q == LAST) ? '0 : bot_idx_q + 1'b1;
          bot_lap_d  = (bot_idx_q == LAST) ? !bot_lap_q : bot_lap_q;
          push_cnt_d = push_cnt_q + 1'b1;
        end
      end
      MODE_POP: begin
        if (held_now == '0) begin
          status = STATUS_EMPTY;
        end else if (held_now == HW'(1)) begin
          // The last entry leaves through the top, as a steal would.
          rd        = 1'b1;
          addr      = top_idx_q;
          top_idx_d = (top_idx_q == LAST) ? '0 : top_idx_q + 1'b1;
          top_lap_d = (top_idx_q == LAST) ? !top_lap_q : top_lap_q;
          pop_cnt_d = pop_cnt_q + 1'b1;
        end else begin
          rd        = 1'b1;
          bot_idx_d = (bot_idx_q == '0) ? LAST : bot_idx_q - 1'b1;
          bot_lap_d = (bot_idx_q == '0) ? !bot_lap_q : bot_lap_q;
          addr      = bot_idx_d;
          pop_cnt_d = pop_cnt_q + 1'b1;
        end
      end
      MODE_STEAL: begin
        try_cnt_d = try_cnt_q + 1'b1;
        if (held_now == '0) begin
          status = STATUS_EMPTY;
        end else begin
          rd          = 1'b1;
          addr        = top_idx_q;
          top_idx_d   = (top_idx_q == LAST) ? '0 : top_idx_q + 1'b1;
          top_lap_d   = (top_idx_q == LAST) ? !top_lap_q : top_lap_q;
          steal_cnt_d = steal_cnt_q + 1'b1;
        end
      end
      MODE_NONE: begin
      end
    endcase
  end

  always_comb begin
    cmd_o.wr                  = wr;
    cmd_o.rd                  = rd;
    cmd_o.wdata               = req_i.job_handle;
    cmd_o.rsp.status          = status;
    cmd_o.rsp.job_out         = '0;
    cmd_o.rsp.occupancy       = held_next[OCC_W-1:0];
    cmd_o.rsp.push_total      = push_cnt_d;
    cmd_o.rsp.pop_total       = pop_cnt_d;
    cmd_o.rsp.steal_total     = steal_cnt_d;
    cmd_o.rsp.steal_try_total = try_cnt_d;
    cmd_addr_o                = addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_lap_q   <= 1'b0;
      top_idx_q   <= '0;
      bot_lap_q   <= 1'b0;
      bot_idx_q   <= '0;
      push_cnt_q  <= '0;
      pop_cnt_q   <= '0;
      steal_cnt_q <= '0;
      try_cnt_q   <= '0;
    end else if (accept) begin
      top_lap_q   <= top_lap_d;
      top_idx_q   <= top_idx_d;
      bot_lap_q   <= bot_lap_d;
      bot_idx_q   <= bot_idx_d;
      push_cnt_q  <= push_cnt_d;
      pop_cnt_q   <= pop_cnt_d;
      steal_cnt_q <= steal_cnt_d;
      try_cnt_q   <= try_cnt_d;
    end
  end

endmodule

### src/wsd_back.sv
// Back end of the deque: performs the ring access of each command and queues the result.
// Depends on wsd_pkg, wsd_ram and wsd_fifo.
module wsd_back import wsd_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_empty_i,
  input  cmd_t                     cmd_i,
  input  logic [$clog2(DEPTH)-1:0] cmd_addr_i,
  output logic                     cmd_pop_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output rsp_t                     rsp_o
);

  localparam int unsigned LW = $clog2(RSPQ_DEPTH + 1);
  localparam int unsigned SW = LW + 1;

  logic [LW-1:0]    level;
  logic             take;
  logic             r_valid_q;
  logic             r_rd_q;
  rsp_t             r_rsp_q;
  logic [JOB_W-1:0] rdata;
  rsp_t             rsp_done;
  logic [$bits(rsp_t)-1:0] rspq_data;

  // A command is taken only when the result queue has room for it and for the one
  // whose read is still in flight, so a result never has to wait outside the queue.
  assign take      = !cmd_empty_i && (({1'b0, level} + SW'(r_valid_q)) < SW'(RSPQ_DEPTH));
  assign cmd_pop_o = take;

  wsd_ram #(
    .WIDTH(JOB_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (take && cmd_i.wr),
    .waddr_i(cmd_addr_i),
    .wdata_i(cmd_i.wdata),
    .re_i   (take && cmd_i.rd),
    .raddr_i(cmd_addr_i),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      r_rd_q  <= cmd_i.rd;
      r_rsp_q <= cmd_i.rsp;
    end
  end

  always_comb begin
    rsp_done = r_rsp_q;
    if (r_rd_q) begin
      rsp_done.job_out = rdata;
    end
  end

  wsd_fifo #(
    .WIDTH($bits(rsp_t)),
    .DEPTH(RSPQ_DEPTH)
  ) u_rspq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (r_valid_q),
    .data_i (rsp_done),
    .full_o (),
    .pop_i  (pop_i),
    .data_o (rspq_data),
    .empty_o(empty_o),
    .level_o(level)
  );

  assign rsp_o = rsp_t'(rspq_data);

endmodule

### src/work_stealing_deque.sv
// Work-stealing task deque. The owner pushes and pops job handles at the bottom of a ring of
// DEPTH entries (last-in first-out) and a thief steals from the top (first-in first-out).
// Requests are served strictly one after another in acceptance order, and each request
// produces exactly one result carrying a status, the handle taken, the occupancy after the
// request and four wrapping event counters. The block accepts one request per clock cycle
// for as long as results are popped as fast. A result passes from the front end, which
// updates the pointers and counters, through the command queue to the back end, whose ring
// memory has a registered read port and makes at most one access per request, and then
// waits in the result queue until popped. The ring needs no clearing after reset: only
// slots written by a push are ever read.
`include "work_stealing_deque_assert.svh"

module work_stealing_deque import wsd_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output rsp_t rsp_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned QW = IW + $bits(cmd_t);

  // Front end to command queue.
  logic          cmdq_full;
  logic          cmd_push;
  cmd_t          cmd_in;
  logic [IW-1:0] cmd_addr_in;

  // Command queue to back end.
  logic          cmd_empty;
  logic          cmd_pop;
  logic [QW-1:0] cmdq_out;
  cmd_t          cmd_out;
  logic [IW-1:0] cmd_addr_out;

  // The front end classifies each request and settles its outcome at once, so the
  // pointers are always current for the next request; the memory access follows later.
  wsd_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_push_i (push),
    .req_full_o (full),
    .req_i      (req_i),
    .cmdq_full_i(cmdq_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_addr_o (cmd_addr_in)
  );

  // The command queue keeps ring writes and reads in request order, so a pop that
  // directly follows a push reads the handle that push wrote.
  wsd_fifo #(
    .WIDTH(QW),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i ({cmd_addr_in, cmd_in}),
    .full_o (cmdq_full),
    .pop_i  (cmd_pop),
    .data_o (cmdq_out),
    .empty_o(cmd_empty),
    .level_o()
  );

  assign cmd_out      = cmd_t'(cmdq_out[$bits(cmd_t)-1:0]);
  assign cmd_addr_out = cmdq_out[QW-1:$bits(cmd_t)];

  // The back end performs the ring access and holds finished results until popped.
  wsd_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_addr_i (cmd_addr_out),
    .cmd_pop_o  (cmd_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .rsp_o      (rsp_o)
  );

  // A request that fails or finds nothing never hands out a job.
  `WSD_ASSERT_IMP(a_no_job_on_fail, !empty && (rsp_o.status == STATUS_EMPTY || rsp_o.status == STATUS_FULL || rsp_o.status == STATUS_NULL), rsp_o.job_out == '0, "failed request carries a job handle")

  // A push is rejected as full only when the ring holds all of its entries.
  `WSD_ASSERT_IMP(a_full_occupancy, !empty && rsp_o.status == STATUS_FULL, rsp_o.occupancy == OCC_W'(DEPTH), "full status with ring not full")

  // Every accepted request is waiting in the command queue in the next cycle.
  `WSD_ASSERT_NXT(a_accept_queued, push && !full, !cmd_empty, "accepted request missing from the command queue")

endmodule

### verif/work_stealing_deque_tb.sv
// Self-checking testbench for the work-stealing deque: random and directed requests
// are checked against a cycle-free predictor of the ring, its pointers and its counters.
// Depends on wsd_pkg and the work_stealing_deque top level.

// Scoreboard: predicts the result of every accepted request and holds the
// predictions in acceptance order until the block returns its results.
class deque_scoreboard;
  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_SPAN = 2 * DEPTH;
  localparam int unsigned MAX_PRINT = 100;

  logic [31:0]     ring_slots [DEPTH];
  int unsigned     top_ptr;
  int unsigned     bottom_ptr;
  logic [31:0]     pushes;
  logic [31:0]     pops;
  logic [31:0]     steals;
  logic [31:0]     steal_tries;
  wsd_pkg::rsp_t   expected_rsp [$];
  int unsigned     mismatches;

  function new();
    top_ptr     = 0;
    bottom_ptr  = 0;
    pushes      = '0;
    pops        = '0;
    steals      = '0;
    steal_tries = '0;
    mismatches  = 0;
  endfunction

  function int unsigned held();
    return (bottom_ptr + PTR_SPAN - top_ptr) % PTR_SPAN;
  endfunction

  function int unsigned pending();
    return expected_rsp.size();
  endfunction

  task report(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINT) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  // Works out what the block answers to one request and advances the copy of its state.
  function void note_request(input wsd_pkg::req_t req);
    wsd_pkg::rsp_t rsp;
    int unsigned   count;
    rsp        = '0;
    rsp.status = wsd_pkg::STATUS_DONE;
    count      = held();
    case (req.mode)
      wsd_pkg::MODE_PUSH: begin
        if (req.job_handle == '0) begin
          rsp.status = wsd_pkg::STATUS_NULL;
        end else if (count >= DEPTH) begin
          rsp.status = wsd_pkg::STATUS_FULL;
        end else begin
          ring_slots[bottom_ptr % DEPTH] = req.job_handle;
          bottom_ptr = (bottom_ptr + 1) % PTR_SPAN;
          pushes++;
        end
      end
      wsd_pkg::MODE_POP: begin
        if (count == 0) begin
          rsp.status = wsd_pkg::STATUS_EMPTY;
        end else if (count == 1) begin
          // The last entry leaves through the top, so bottom stays put.
          rsp.job_out = ring_slots[top_ptr % DEPTH];
          top_ptr = (top_ptr + 1) % PTR_SPAN;
          pops++;
        end else begin
          bottom_ptr = (bottom_ptr + PTR_SPAN - 1) % PTR_SPAN;
          rsp.job_out = ring_slots[bottom_ptr % DEPTH];
          pops++;
        end
      end
      wsd_pkg::MODE_STEAL: begin
        steal_tries++;
        if (count == 0) begin
          rsp.status = wsd_pkg::STATUS_EMPTY;
        end else begin
          rsp.job_out = ring_slots[top_ptr % DEPTH];
          top_ptr = (top_ptr + 1) % PTR_SPAN;
          steals++;
        end
      end
      default: begin
      end
    endcase
    rsp.occupancy       = 7'(held());
    rsp.push_total      = pushes;
    rsp.pop_total       = pops;
    rsp.steal_total     = steals;
    rsp.steal_try_total = steal_tries;
    expected_rsp.insert(expected_rsp.size(), rsp);
  endfunction

  task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  task check_result(input wsd_pkg::rsp_t got);
    wsd_pkg::rsp_t want;
    if (expected_rsp.size() == 0) begin
      report("result returned with no request outstanding");
    end else begin
      want = expected_rsp.pop_front();
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("job_out", got.job_out, want.job_out);
      compare_field("occupancy", 32'(got.occupancy), 32'(want.occupancy));
      compare_field("push_total", got.push_total, want.push_total);
      compare_field("pop_total", got.pop_total, want.pop_total);
      compare_field("steal_total", got.steal_total, want.steal_total);
      compare_field("steal_try_total", got.steal_try_total, want.steal_try_total);
    end
  endtask
endclass

module work_stealing_deque_tb;
  import wsd_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned TIMEOUT_CYCLES = 300000;
  localparam int unsigned PHASE_ITEMS    = 440;
  localparam int unsigned HOLD_CYCLES    = 160;
  localparam int unsigned TAIL_CYCLES    = 10;

  // Bias of a random episode: a mix, a run of pushes that fills the ring, or a run
  // of pops and steals that drains it.
  typedef enum int unsigned {
    BIAS_MIXED,
    BIAS_FILL,
    BIAS_DRAIN
  } bias_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  req_t req_i  = '0;
  logic full;
  logic empty;
  rsp_t rsp_o;

  // Percentages of cycles in which the sender stays idle and the receiver stalls.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Cycles left in a long receiver hold-off; counted down by the receiver process.
  int unsigned hold_left      = 0;

  deque_scoreboard sb = new();

  work_stealing_deque u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req_i),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp_o)
  );

  initial begin
    forever begin
      #(CLK_PERIOD / 2) clk_i = ~clk_i;
    end
  end

  // Hard stop in case the block deadlocks or stops answering.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

  // Monitor. Both handshakes are sampled at the rising edge, where every input was
  // settled at the last falling edge and every output still shows its pre-edge value.
  // The result is checked before the request of the same edge is noted, since a
  // request can never be answered in the cycle it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        sb.check_result(rsp_o);
      end
      if (push && !full) begin
        sb.note_request(req_i);
      end
    end
  end

  // Receiver. It drops pop at random according to the stall percentage, and holds
  // it low for the whole of a hold-off so that the result queue and then the
  // request side back up.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one request and returns at the falling edge after it was accepted.
  // Must be entered at a falling edge. While idle the payload is scrambled, which
  // the block must ignore since push is low. When the next request follows at
  // once, push simply stays high, so it is never lowered and raised in one step.
  task automatic send_req(input req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      push  <= 1'b0;
      req_i <= req_t'({$urandom(), $urandom()});
      @(negedge clk_i);
    end
    push  <= 1'b1;
    req_i <= req;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Stops offering requests until every outstanding result has come back.
  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_handle();
    int unsigned pick;
    logic [31:0] handle;
    pick = $urandom_range(99);
    if (pick < 4) begin
      handle = 32'hFFFF_FFFF;
    end else if (pick < 8) begin
      handle = 32'h0000_0001;
    end else begin
      handle = $urandom();
    end
    if (handle == '0) begin
      handle = 32'h0000_0001;
    end
    return handle;
  endfunction

  function automatic req_t make_req(input bias_e bias);
    req_t        req;
    int unsigned pick;
    int unsigned push_w;
    int unsigned pop_w;
    int unsigned steal_w;
    case (bias)
      BIAS_FILL: begin
        push_w = 80; pop_w = 8; steal_w = 10;
      end
      BIAS_DRAIN: begin
        push_w = 20; pop_w = 40; steal_w = 38;
      end
      default: begin
        push_w = 46; pop_w = 25; steal_w = 25;
      end
    endcase
    pick = $urandom_range(99);
    req.job_handle = $urandom();
    if (pick < push_w) begin
      req.mode = MODE_PUSH;
      // A few null handles, which must be turned away whatever the occupancy.
      req.job_handle = ($urandom_range(99) < 4) ? '0 : rand_handle();
    end else if (pick < push_w + pop_w) begin
      req.mode = MODE_POP;
    end else if (pick < push_w + pop_w + steal_w) begin
      req.mode = MODE_STEAL;
    end else begin
      req.mode = MODE_NONE;
    end
    return req;
  endfunction

  // Random requests in episodes of random bias and length, so the ring swings
  // between empty and full many times within a phase.
  task automatic run_random(input int unsigned items);
    int unsigned sent;
    int unsigned span;
    bias_e       bias;
    sent = 0;
    while (sent < items) begin
      bias = bias_e'($urandom_range(2));
      span = $urandom_range(20, 120);
      repeat (span) begin
        send_req(make_req(bias));
        sent++;
      end
    end
  endtask

  // Short directed sequence on an empty ring: empty pop and steal, the unused
  // mode, a null push, handles at the extremes, last-in first-out pops against
  // first-in first-out steals, and the last entry taken by both a pop and a steal.
  task automatic run_directed();
    send_req('{mode: MODE_STEAL, job_handle: 32'h1234_5678});
    send_req('{mode: MODE_POP,   job_handle: 32'hFFFF_FFFF});
    send_req('{mode: MODE_NONE,  job_handle: 32'hDEAD_BEEF});
    send_req('{mode: MODE_PUSH,  job_handle: 32'h0000_0000});
    send_req('{mode: MODE_PUSH,  job_handle: 32'hFFFF_FFFF});
    send_req('{mode: MODE_PUSH,  job_handle: 32'h0000_0001});
    send_req('{mode: MODE_PUSH,  job_handle: 32'h8000_0000});
    send_req('{mode: MODE_PUSH,  job_handle: 32'h5555_5555});
    send_req('{mode: MODE_NONE,  job_handle: 32'h0000_0000});
    send_req('{mode: MODE_POP,   job_handle: 32'h0000_0000});
    send_req('{mode: MODE_STEAL, job_handle: 32'hAAAA_AAAA});
    send_req('{mode: MODE_POP,   job_handle: 32'h0000_0000});
    send_req('{mode: MODE_POP,   job_handle: 32'h0F0F_0F0F});
    send_req('{mode: MODE_POP,   job_handle: 32'h0000_0000});
    send_req('{mode: MODE_STEAL, job_handle: 32'h0000_0000});
    send_req('{mode: MODE_PUSH,  job_handle: 32'hAAAA_AAAA});
    send_req('{mode: MODE_STEAL, job_handle: 32'h0000_0000});
    send_req('{mode: MODE_PUSH,  job_handle: 32'h0000_0000});
    send_req('{mode: MODE_NONE,  job_handle: 32'hFFFF_FFFF});
  endtask

  initial begin
    repeat (RESET_CYCLES) begin
      @(negedge clk_i);
    end
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    wait_drained();

    // Back-pressure: the receiver holds off for a long stretch while requests keep
    // coming as fast as the block takes them, so the internal queues fill and
    // full rises. The hold is armed at a rising edge, away from the receiver.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    @(negedge clk_i);
    run_random(PHASE_ITEMS);
    wait_drained();

    // Sender mostly idle.
    send_idle_pct  = 72;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);
    wait_drained();

    // Receiver mostly stalling.
    send_idle_pct  = 0;
    recv_stall_pct = 72;
    run_random(PHASE_ITEMS);
    wait_drained();

    // Both sides idling now and then.
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    run_random(PHASE_ITEMS);
    wait_drained();

    // A few quiet cycles catch any result that the block sends without a request.
    repeat (TAIL_CYCLES) begin
      @(posedge clk_i);
    end
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never returned", sb.pending()));
    end
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
